// ===== design/pbcc_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and codes for the pairwise co-occurrence counter
package pbcc_pkg;

    localparam int MAX_VARS    = 32;
    localparam int COUNT_WIDTH = 16;
    localparam int LABEL_WIDTH = 8;
    localparam int VAR_W       = $clog2(MAX_VARS);
    localparam int N_W         = VAR_W + 1;
    localparam int CFG_W       = 8;
    localparam int CFG_IDX_W   = 1;

    localparam logic [N_W-1:0] NUM_MAX = N_W'(MAX_VARS);
    localparam logic [N_W-1:0] NUM_MIN = N_W'(2);

    // request codes
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_CLEAR  = 2'd1;
    localparam logic [1:0] REQ_PAIR   = 2'd2;
    localparam logic [1:0] REQ_SINGLE = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_MISMATCH = 2'd1;
    localparam logic [1:0] STAT_BAD_IDX  = 2'd2;
    localparam logic [1:0] STAT_SAT      = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_VARS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_KEY = 1'b1;

    typedef struct packed {
        logic [1:0]             req_type;
        logic [MAX_VARS-1:0]    individual_bits;
        logic [LABEL_WIDTH-1:0] cluster_label;
        logic [VAR_W-1:0]       var_first;
        logic [VAR_W-1:0]       var_second;
        logic [1:0]             pattern;
    } req_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] count_value;
        logic [COUNT_WIDTH-1:0] pool_count;
        logic [1:0]             status;
    } rsp_t;

    // token walking down the cell row, bits[0] is the bit of variable k
    typedef struct packed {
        logic                valid;
        logic                clr;
        logic [N_W-1:0]      k;
        logic [N_W-1:0]      lim;
        logic [MAX_VARS-1:0] bits;
    } tok_t;

    typedef struct packed {
        logic             rd_en;
        logic [VAR_W-1:0] rd_addr;
        logic             single_clr;
    } ctl_t;

    typedef struct packed {
        logic [VAR_W-1:0] first;
        logic [1:0]       pattern;
    } sel_t;

    // the four pattern counts of one pair, indexed by 2*bit_j+bit_k
    typedef logic [3:0][COUNT_WIDTH-1:0] quad_t;

endpackage

// ===== design/pbcc_cell.sv =====
`timescale 1ns / 1ps
// one cell of the row: pair counts of one first variable and its ones count
module pbcc_cell
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  pbcc_pkg::tok_t                 tok_in,
    output pbcc_pkg::tok_t                 tok_out,
    input  pbcc_pkg::ctl_t                 ctl,
    input  logic                           own_bit,
    input  logic                           single_inc,
    output pbcc_pkg::quad_t                quad,
    output logic [pbcc_pkg::COUNT_WIDTH-1:0] single
);
    import pbcc_pkg::*;

    tok_t                   tok_reg;
    logic                   hit;
    logic [VAR_W-1:0]       rd_addr;
    quad_t                  mem [MAX_VARS];
    quad_t                  rdata_reg;
    quad_t                  wdata;
    logic                   wr_reg;
    logic [VAR_W-1:0]       waddr_reg;
    logic [1:0]             lane_reg;
    logic                   clr_reg;
    logic [COUNT_WIDTH-1:0] single_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg    <= '0;
            wr_reg     <= 1'b0;
            single_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_in;
            wr_reg  <= hit;
            if (ctl.single_clr)
            begin
                single_reg <= '0;
            end
            else if (single_inc && (single_reg != '1))
            begin
                single_reg <= single_reg + COUNT_WIDTH'(1);
            end
        end
    end

    // next cell sees the following variable
    always_comb
    begin
        tok_out      = tok_reg;
        tok_out.k    = tok_reg.k + N_W'(1);
        tok_out.bits = tok_reg.bits >> 1;
    end

    assign hit     = tok_reg.valid && (tok_reg.k < tok_reg.lim);
    assign rd_addr = ctl.rd_en ? ctl.rd_addr : tok_reg.k[VAR_W-1:0];

    always_ff @(posedge clk)
    begin
        waddr_reg <= tok_reg.k[VAR_W-1:0];
        lane_reg  <= {own_bit, tok_reg.bits[0]};
        clr_reg   <= tok_reg.clr;
    end

    // read-modify-write, consecutive tokens never share an address
    always_comb
    begin
        wdata = rdata_reg;
        if (clr_reg)
        begin
            wdata = '0;
        end
        else if (rdata_reg[lane_reg] != '1)
        begin
            wdata[lane_reg] = rdata_reg[lane_reg] + COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_reg)
        begin
            mem[waddr_reg] <= wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign quad   = rdata_reg;
    assign single = single_reg;

endmodule

// ===== design/pbcc_seq.sv =====
`timescale 1ns / 1ps
// request sequencer: config registers, pool count, token source and replies
module pbcc_seq
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  pbcc_pkg::req_t                   req,
    output logic                             done,
    output pbcc_pkg::rsp_t                   rsp,
    input  logic                             cfg_we,
    input  logic [pbcc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pbcc_pkg::CFG_W-1:0]       cfg_data,
    output pbcc_pkg::tok_t                   tok,
    output pbcc_pkg::ctl_t                   ctl,
    output logic [pbcc_pkg::MAX_VARS-1:0]    own_bits,
    output logic [pbcc_pkg::MAX_VARS-1:0]    inc_mask,
    output pbcc_pkg::sel_t                   sel,
    input  logic [pbcc_pkg::COUNT_WIDTH-1:0] pair_val,
    input  logic [pbcc_pkg::COUNT_WIDTH-1:0] single_val
);
    import pbcc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SWEEP = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_RADDR = 3'd3;
    localparam logic [2:0] S_RDATA = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [VAR_W-1:0]       cnt_reg, cnt_next;
    logic [N_W-1:0]         lim_reg, lim_next;
    logic                   clr_reg, clr_next;
    logic                   quiet_reg, quiet_next;
    logic [COUNT_WIDTH-1:0] pool_reg, pool_next;
    logic                   done_reg, done_next;
    rsp_t                   rsp_reg, rsp_next;
    logic [MAX_VARS-1:0]    bits_reg, bits_next;
    logic [VAR_W-1:0]       vf_reg, vf_next;
    logic [VAR_W-1:0]       vs_reg, vs_next;
    logic [1:0]             pat_reg, pat_next;
    logic                   pair_op_reg, pair_op_next;
    logic [N_W-1:0]         num_vars_reg;
    logic [LABEL_WIDTH-1:0] key_reg;
    logic [N_W-1:0]         n_act;
    logic [MAX_VARS-1:0]    nmask;
    logic                   add_ok;
    logic                   clr_req;

    always_comb
    begin
        if (num_vars_reg < NUM_MIN)
        begin
            n_act = NUM_MIN;
        end
        else if (num_vars_reg > NUM_MAX)
        begin
            n_act = NUM_MAX;
        end
        else
        begin
            n_act = num_vars_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_VARS; i++)
        begin
            nmask[i] = (N_W'(i) < n_act);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        lim_next     = lim_reg;
        clr_next     = clr_reg;
        quiet_next   = quiet_reg;
        pool_next    = pool_reg;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;
        bits_next    = bits_reg;
        vf_next      = vf_reg;
        vs_next      = vs_reg;
        pat_next     = pat_reg;
        pair_op_next = pair_op_reg;
        add_ok       = 1'b0;
        clr_req      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    vf_next              = req.var_first;
                    vs_next              = req.var_second;
                    pat_next             = req.pattern;
                    bits_next            = req.individual_bits;
                    rsp_next.count_value = '0;
                    rsp_next.pool_count  = pool_reg;
                    rsp_next.status      = STAT_OK;
                    case (req.req_type)
                        REQ_ADD:
                        begin
                            if (req.cluster_label != key_reg)
                            begin
                                done_next       = 1'b1;
                                rsp_next.status = STAT_MISMATCH;
                            end
                            else if (pool_reg == '1)
                            begin
                                done_next       = 1'b1;
                                rsp_next.status = STAT_SAT;
                            end
                            else
                            begin
                                add_ok     = 1'b1;
                                pool_next  = pool_reg + COUNT_WIDTH'(1);
                                lim_next   = n_act;
                                clr_next   = 1'b0;
                                cnt_next   = '0;
                                state_next = S_SWEEP;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            clr_req    = 1'b1;
                            pool_next  = '0;
                            lim_next   = NUM_MAX;
                            clr_next   = 1'b1;
                            cnt_next   = '0;
                            state_next = S_SWEEP;
                        end
                        REQ_PAIR:
                        begin
                            if ((req.var_first < req.var_second) &&
                                ({1'b0, req.var_second} < n_act))
                            begin
                                pair_op_next = 1'b1;
                                state_next   = S_RADDR;
                            end
                            else
                            begin
                                done_next       = 1'b1;
                                rsp_next.status = STAT_BAD_IDX;
                            end
                        end
                        default:
                        begin
                            if ({1'b0, req.var_first} < n_act)
                            begin
                                pair_op_next = 1'b0;
                                state_next   = S_RDATA;
                            end
                            else
                            begin
                                done_next       = 1'b1;
                                rsp_next.status = STAT_BAD_IDX;
                            end
                        end
                    endcase
                end
            end
            S_SWEEP:
            begin
                if ({1'b0, cnt_reg} == (lim_reg - N_W'(2)))
                begin
                    cnt_next   = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + VAR_W'(1);
                end
            end
            S_DRAIN:
            begin
                // last token still has its read and write stages to pass
                if (cnt_reg == VAR_W'(2))
                begin
                    done_next            = !quiet_reg;
                    quiet_next           = 1'b0;
                    rsp_next.count_value = '0;
                    rsp_next.pool_count  = pool_reg;
                    rsp_next.status      = STAT_OK;
                    state_next           = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + VAR_W'(1);
                end
            end
            S_RADDR:
            begin
                state_next = S_RDATA;
            end
            S_RDATA:
            begin
                done_next            = 1'b1;
                rsp_next.count_value = pair_op_reg ? pair_val : single_val;
                rsp_next.pool_count  = pool_reg;
                rsp_next.status      = STAT_OK;
                state_next           = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // after reset the row runs a clearing sweep with no reply
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_SWEEP;
            cnt_reg      <= '0;
            lim_reg      <= NUM_MAX;
            clr_reg      <= 1'b1;
            quiet_reg    <= 1'b1;
            pool_reg     <= '0;
            done_reg     <= 1'b0;
            num_vars_reg <= NUM_MAX;
            key_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            lim_reg   <= lim_next;
            clr_reg   <= clr_next;
            quiet_reg <= quiet_next;
            pool_reg  <= pool_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NUM_VARS:    num_vars_reg <= cfg_data[N_W-1:0];
                    REG_CLUSTER_KEY: key_reg      <= cfg_data[LABEL_WIDTH-1:0];
                    default:         key_reg      <= key_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg     <= rsp_next;
        bits_reg    <= bits_next;
        vf_reg      <= vf_next;
        vs_reg      <= vs_next;
        pat_reg     <= pat_next;
        pair_op_reg <= pair_op_next;
    end

    always_comb
    begin
        tok.valid = (state_reg == S_SWEEP);
        tok.clr   = clr_reg;
        tok.k     = {1'b0, cnt_reg} + N_W'(1);
        tok.lim   = lim_reg;
        tok.bits  = bits_reg >> ({1'b0, cnt_reg} + N_W'(1));
    end

    assign ctl.rd_en      = (state_reg == S_RADDR);
    assign ctl.rd_addr    = vs_reg;
    assign ctl.single_clr = clr_req;
    assign own_bits       = bits_reg;
    assign inc_mask       = add_ok ? (req.individual_bits & nmask) : '0;
    assign sel.first      = vf_reg;
    assign sel.pattern    = pat_reg;
    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign rsp            = rsp_reg;

endmodule

// ===== design/pairwise_bit_cooccurrence_counter_core.sv =====
`timescale 1ns / 1ps
// add runs a token sweep over the n variables in use; clear sweeps the full row
// pair read has address and data states, single read only data; one request at a time
// add time is set by the n-1 tokens fed into the cell row, one per cycle, plus read and write
// reset: counts and key cleared, num vars at max, pair memories wiped by a sweep, busy high
// results are strobed for one cycle on done; the receiver cannot stall
module pairwise_bit_cooccurrence_counter_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  pbcc_pkg::req_t                 req,
    output logic                           done,
    output pbcc_pkg::rsp_t                 rsp,
    input  logic                           cfg_we,
    input  logic [pbcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pbcc_pkg::CFG_W-1:0]     cfg_data
);
    import pbcc_pkg::*;

    tok_t                   tok_src;
    tok_t                   tok_in  [MAX_VARS];
    tok_t                   tok_out [MAX_VARS];
    ctl_t                   ctl;
    sel_t                   sel;
    logic [MAX_VARS-1:0]    own_bits;
    logic [MAX_VARS-1:0]    inc_mask;
    quad_t                  quads   [MAX_VARS];
    logic [COUNT_WIDTH-1:0] singles [MAX_VARS];
    logic [COUNT_WIDTH-1:0] pair_val;
    logic [COUNT_WIDTH-1:0] single_val;

    pbcc_seq u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .rsp        (rsp),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .tok        (tok_src),
        .ctl        (ctl),
        .own_bits   (own_bits),
        .inc_mask   (inc_mask),
        .sel        (sel),
        .pair_val   (pair_val),
        .single_val (single_val)
    );

    assign tok_in[0] = tok_src;

    genvar g;
    generate
        for (g = 0; g < MAX_VARS; g++)
        begin : g_cell
            if (g > 0)
            begin : g_link
                assign tok_in[g] = tok_out[g-1];
            end
            pbcc_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .tok_in     (tok_in[g]),
                .tok_out    (tok_out[g]),
                .ctl        (ctl),
                .own_bit    (own_bits[g]),
                .single_inc (inc_mask[g]),
                .quad       (quads[g]),
                .single     (singles[g])
            );
        end
    endgenerate

    // readback select from the cell of the first variable
    assign pair_val   = quads[sel.first][sel.pattern];
    assign single_val = singles[sel.first];

endmodule
